[rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

[rtl/dfr_pkg.sv]
package dfr_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'h55;
	localparam logic [7:0] SYNC_SECOND = 8'hAA;
	localparam logic [7:0] MIN_LEN     = 8'd3;
	// XOR of the two sync bytes, seed of the frame check
	localparam logic [7:0] SYNC_XOR    = SYNC_FIRST ^ SYNC_SECOND;

	// One pending request from the parser to the emitter
	typedef struct packed {
		logic       header;  // emit sync pair before data
		logic [7:0] data;    // length byte or body byte
		logic       last;    // data is the last byte of the frame
		logic       good;    // frame check passed (only with last)
	} req_t;

endpackage

[rtl/dfr_rx_if.sv]
interface dfr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

[rtl/dfr_tx_if.sv]
interface dfr_tx_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       first_of_frame;
	logic       last_of_frame;
	logic       check_good;

	modport source (
		output valid, output frame_byte, output first_of_frame,
		output last_of_frame, output check_good, input ready
	);
	modport sink (
		input valid, input frame_byte, input first_of_frame,
		input last_of_frame, input check_good, output ready
	);
endinterface

[rtl/sync_length_xor_deframer_core.sv]
// Sync / length / XOR deframer.
// rx: one received byte per request (rx_byte). tx: one frame byte per
// request with first_of_frame, last_of_frame and check_good marks.
// The block hunts for 0x55 0xAA; the next byte is the total frame length.
// A length of 3 or more opens a frame: 0x55, 0xAA and the length go out as
// three requests, then each body byte goes out as one. check_good is set on
// the last byte when the XOR of all frame bytes is zero. Lengths 0 to 2 and
// sync bytes are consumed silently.
// A byte is registered in the parser stage, then in the output register,
// before its first result is offered.
// Throughput: one byte per cycle for sync and body bytes while tx does not
// stall; a length byte that opens a frame holds rx.ready low until the last
// of its three header results is taken. The single output port sets this rate.
// Reset (arst_n low) returns to hunting and empties both stages.
// When tx stalls, the output register holds and the parser stage holds;
// rx.ready stays high while the parser stage is empty, then drops.
module sync_length_xor_deframer_core (
	input  logic     clk,
	input  logic     arst_n,
	dfr_rx_if.sink   rx,
	dfr_tx_if.source tx
);

	logic          req_valid;
	dfr_pkg::req_t req;
	logic          take;

	dfr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.req_valid (req_valid),
		.req       (req),
		.take      (take)
	);

	dfr_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.take      (take),
		.tx        (tx)
	);

endmodule

[rtl/dfr_parser.sv]
module dfr_parser (
	input  logic           clk,
	input  logic           arst_n,
	dfr_rx_if.sink         rx,
	output logic           req_valid,
	output dfr_pkg::req_t  req,
	input  logic           take
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_SYNC2,
		PH_LEN,
		PH_BODY
	} phase_t;

	phase_t        phase_q, phase_n;
	logic [7:0]    left_q, left_n;
	logic [7:0]    xor_q, xor_n;
	logic          valid_s1;
	dfr_pkg::req_t req_s1;
	dfr_pkg::req_t req_n;
	logic          emit_n;
	logic          accept;

	// Take a new byte when the stage is empty or drains this cycle
	assign rx.ready  = !valid_s1 || take;
	assign accept    = rx.valid && rx.ready;
	assign req_valid = valid_s1;
	assign req       = req_s1;

	// Advance the hunt / frame state for the offered byte
	always_comb begin
		phase_n      = phase_q;
		left_n       = left_q;
		xor_n        = xor_q;
		emit_n       = 1'b0;
		req_n.header = 1'b0;
		req_n.data   = rx.rx_byte;
		req_n.last   = 1'b0;
		req_n.good   = 1'b0;
		case (phase_q)
			PH_HUNT: begin
				if (rx.rx_byte == dfr_pkg::SYNC_FIRST) phase_n = PH_SYNC2;
			end
			PH_SYNC2: begin
				if (rx.rx_byte == dfr_pkg::SYNC_SECOND) phase_n = PH_LEN;
				else if (rx.rx_byte != dfr_pkg::SYNC_FIRST) phase_n = PH_HUNT;
			end
			PH_LEN: begin
				if (rx.rx_byte < dfr_pkg::MIN_LEN) begin
					phase_n = PH_HUNT;
				end else begin
					xor_n        = dfr_pkg::SYNC_XOR ^ rx.rx_byte;
					left_n       = rx.rx_byte - dfr_pkg::MIN_LEN;
					emit_n       = 1'b1;
					req_n.header = 1'b1;
					req_n.last   = (left_n == 8'd0);
					req_n.good   = req_n.last && (xor_n == 8'd0);
					phase_n      = req_n.last ? PH_HUNT : PH_BODY;
				end
			end
			PH_BODY: begin
				xor_n = xor_q ^ rx.rx_byte;
				if (left_q != 8'd0) left_n = left_q - 8'd1;
				emit_n     = 1'b1;
				req_n.last = (left_n == 8'd0);
				req_n.good = req_n.last && (xor_n == 8'd0);
				if (req_n.last) phase_n = PH_HUNT;
			end
			default: phase_n = PH_HUNT;
		endcase
	end

	// Hold state and request; update on an accepted byte, empty on a take alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			left_q   <= 8'd0;
			xor_q    <= 8'd0;
			valid_s1 <= 1'b0;
			req_s1   <= '0;
		end else begin
			if (accept) begin
				phase_q  <= phase_n;
				left_q   <= left_n;
				xor_q    <= xor_n;
				valid_s1 <= emit_n;
				if (emit_n) req_s1 <= req_n;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

endmodule

[rtl/dfr_emitter.sv]
module dfr_emitter (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  dfr_pkg::req_t  req,
	output logic           take,
	dfr_tx_if.source       tx
);

	logic [1:0] sub_q;
	logic       load;
	logic       tx_valid_q;
	logic [7:0] byte_q;
	logic       first_q;
	logic       last_q;
	logic       good_q;
	logic [7:0] byte_n;
	logic       first_n;
	logic       last_n;
	logic       good_n;
	logic       final_sub;

	assign load      = !tx_valid_q || tx.ready;
	assign final_sub = !req.header || (sub_q == 2'd2);
	assign take      = req_valid && load && final_sub;

	assign tx.valid          = tx_valid_q;
	assign tx.frame_byte     = byte_q;
	assign tx.first_of_frame = first_q;
	assign tx.last_of_frame  = last_q;
	assign tx.check_good     = good_q;

	// Pick the result for the current position within the request
	always_comb begin
		byte_n  = req.data;
		first_n = 1'b0;
		last_n  = req.last;
		good_n  = req.good;
		if (req.header) begin
			case (sub_q)
				2'd0: begin
					byte_n  = dfr_pkg::SYNC_FIRST;
					first_n = 1'b1;
					last_n  = 1'b0;
					good_n  = 1'b0;
				end
				2'd1: begin
					byte_n = dfr_pkg::SYNC_SECOND;
					last_n = 1'b0;
					good_n = 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Advance the header position and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q      <= 2'd0;
			tx_valid_q <= 1'b0;
		end else if (load) begin
			tx_valid_q <= req_valid;
			if (req_valid) sub_q <= final_sub ? 2'd0 : sub_q + 2'd1;
		end
	end

	// Load the output payload
	always_ff @(posedge clk) begin
		if (load && req_valid) begin
			byte_q  <= byte_n;
			first_q <= first_n;
			last_q  <= last_n;
			good_q  <= good_n;
		end
	end

endmodule

[rtl/dfr_checker.sv]
`include "assert_macros.svh"

module dfr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       tx_valid,
	input logic       tx_ready,
	input logic [7:0] frame_byte,
	input logic       first_of_frame,
	input logic       last_of_frame,
	input logic       check_good
);

	// A stalled result holds
	`ASSERT_NEXT(a_tx_hold, clk, arst_n, tx_valid && !tx_ready, tx_valid && $stable(frame_byte))

	// A good check only marks the last byte
	`ASSERT_IMPLY(a_good_last, clk, arst_n, tx_valid && check_good, last_of_frame)

	// A frame opens with the first sync byte and never ends there
	`ASSERT_IMPLY(a_first_sync, clk, arst_n, tx_valid && first_of_frame, frame_byte == dfr_pkg::SYNC_FIRST && !last_of_frame)

	// The second sync byte follows the opening byte at once
	`ASSERT_NEXT(a_second_sync, clk, arst_n, tx_valid && tx_ready && first_of_frame, tx_valid && frame_byte == dfr_pkg::SYNC_SECOND && !first_of_frame)

endmodule

bind sync_length_xor_deframer_core dfr_checker u_dfr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.tx_valid       (tx.valid),
	.tx_ready       (tx.ready),
	.frame_byte     (tx.frame_byte),
	.first_of_frame (tx.first_of_frame),
	.last_of_frame  (tx.last_of_frame),
	.check_good     (tx.check_good)
);
